// ===== rtl/core/clhg_pkg.sv =====
// Shared types, widths and constants for the CPU load hysteresis governor.
package clhg_pkg;

   // History depth default
   localparam int HISTORY_DEPTH_DEF = 240;

   // Field widths
   localparam int DELTA_W    = 48;
   localparam int USAGE_W    = 10;
   localparam int LEVEL_W    = 4;
   localparam int CORES_W    = 9;
   localparam int INTERVAL_W = 16;
   localparam int THRESH_W   = 10;
   localparam int AGE_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Divider sizing: numerator is delta*100, denominator cores*interval
   localparam int NUM_W     = DELTA_W + 7;
   localparam int DEN_W     = CORES_W + INTERVAL_W;
   localparam int DIV_STEPS = USAGE_W;
   localparam int DIV_CNT_W = 4;

   localparam logic [USAGE_W-1:0]    USAGE_MAX    = 10'd1023;
   localparam logic [LEVEL_W-1:0]    LEVEL_MIN    = 4'd1;
   localparam logic [LEVEL_W-1:0]    LEVEL_MAX    = 4'd9;
   localparam logic [CORES_W-1:0]    CORES_RST    = 9'd1;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd250;
   localparam logic [THRESH_W-1:0]   UPPER_RST    = 10'd92;
   localparam logic [THRESH_W-1:0]   LOWER_RST    = 10'd72;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_CORES     = 2'd0,
      CSR_TICK_INTERVAL = 2'd1,
      CSR_UPPER_THRESH  = 2'd2,
      CSR_LOWER_THRESH  = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCALE_ALL,
      ST_START_ALL,
      ST_WAIT_ALL,
      ST_SCALE_WRK,
      ST_START_WRK,
      ST_WAIT_WRK,
      ST_UPDATE,
      ST_READ_ADDR,
      ST_READ_DATA
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic scale;
      logic sel_wrk;
      logic div_start;
      logic store_all;
      logic store_wrk;
      logic update;
      logic read_issue;
      logic out_read;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_read;
      logic div_busy;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [USAGE_W-1:0] all_pc;
      logic [USAGE_W-1:0] wrk_pc;
      logic [LEVEL_W-1:0] level;
   } ring_entry_type;

endpackage

// ===== rtl/core/clhg_if.sv =====
// Request and response channel interfaces of the governor.
interface clhg_req_if import clhg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               func;
   logic [DELTA_W-1:0] process_time_ms;
   logic [DELTA_W-1:0] thread_time_ms;
   logic [AGE_W-1:0]   history_age;

   modport source (output valid, func, process_time_ms, thread_time_ms, history_age,
                   input ready);
   modport sink (input valid, func, process_time_ms, thread_time_ms, history_age,
                 output ready);
endinterface

interface clhg_rsp_if import clhg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [USAGE_W-1:0] usage_all_pc;
   logic [USAGE_W-1:0] usage_worker_pc;
   logic [LEVEL_W-1:0] perf_level;
   logic               level_changed;

   modport source (output valid, usage_all_pc, usage_worker_pc, perf_level, level_changed,
                   input ready);
   modport sink (input valid, usage_all_pc, usage_worker_pc, perf_level, level_changed,
                 output ready);
endinterface

// ===== rtl/core/cpu_load_hysteresis_governor.sv =====
// A tick item runs the shared 11-step divider twice, then its result is registered.
// A history read goes through decode, one registered memory read and an output load.
// One item is in work at a time; the output register lets the next item enter
//   while a result waits. Reset is synchronous, active high, and restores config,
//   level 9, empty history (reads of unwritten entries return 0, 0, 9); no clearing pass.
module cpu_load_hysteresis_governor import clhg_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   clhg_req_if.sink              req_chan,
   clhg_rsp_if.source            rsp_chan
);

   cmd_type    cmd;
   status_type status;

   clhg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   clhg_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_func            (req_chan.func),
      .req_process_time_ms (req_chan.process_time_ms),
      .req_thread_time_ms  (req_chan.thread_time_ms),
      .req_history_age     (req_chan.history_age),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_usage_all_pc    (rsp_chan.usage_all_pc),
      .rsp_usage_worker_pc (rsp_chan.usage_worker_pc),
      .rsp_perf_level      (rsp_chan.perf_level),
      .rsp_level_changed   (rsp_chan.level_changed)
   );

endmodule

// ===== rtl/core/clhg_div.sv =====
// Restoring divider with saturation: quotient = min(num / den, 1023).
module clhg_div import clhg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   output logic               busy,
   output logic [USAGE_W-1:0] quotient
);

   localparam int SH_W = DEN_W + DIV_STEPS;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]     rem_ff;
   logic [SH_W-1:0]      dsh_ff;
   logic [USAGE_W-1:0]   q_ff;
   logic                 sat_ff;
   logic                 ge;

   // Trial compare against the shifted divisor
   assign ge = rem_ff >= NUM_W'(dsh_ff);

   // Step counter: first step checks for overflow, then one quotient bit a step
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Remainder, shifted divisor and quotient
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= {den, {DIV_STEPS{1'b0}}};
         q_ff   <= '0;
         sat_ff <= 1'b0;
      end else if (busy_ff) begin
         dsh_ff <= dsh_ff >> 1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS)) begin
            sat_ff <= ge;
         end else begin
            if (ge) begin
               rem_ff <= rem_ff - NUM_W'(dsh_ff);
            end
            q_ff <= {q_ff[USAGE_W-2:0], ge};
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = sat_ff ? USAGE_MAX : q_ff;

endmodule

// ===== rtl/core/clhg_dp.sv =====
// Datapath: config registers, deltas, divider, level logic, history ring, output register.
module clhg_dp import clhg_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_func,
   input  logic [DELTA_W-1:0]    req_process_time_ms,
   input  logic [DELTA_W-1:0]    req_thread_time_ms,
   input  logic [AGE_W-1:0]      req_history_age,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [USAGE_W-1:0]    rsp_usage_all_pc,
   output logic [USAGE_W-1:0]    rsp_usage_worker_pc,
   output logic [LEVEL_W-1:0]    rsp_perf_level,
   output logic                  rsp_level_changed
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = ((AW > AGE_W) ? AW : AGE_W) + 1;
   localparam int FW = $clog2(HISTORY_DEPTH + 1);

   // Configuration
   logic [CORES_W-1:0]    cores_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [THRESH_W-1:0]   upper_ff;
   logic [THRESH_W-1:0]   lower_ff;

   // Captured item
   func_type           func_ff;
   logic [DELTA_W-1:0] pt_ff;
   logic [DELTA_W-1:0] tt_ff;
   logic [AGE_W-1:0]   age_ff;

   // Architectural state
   logic [DELTA_W-1:0] last_p_ff;
   logic [DELTA_W-1:0] last_t_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [AW-1:0]      head_ff;
   logic [FW-1:0]      fill_ff;

   // Working registers
   logic [DELTA_W-1:0] delta_all_ff;
   logic [DELTA_W-1:0] delta_wrk_ff;
   logic [DEN_W-1:0]   den_all_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [USAGE_W-1:0] usage_all_ff;
   logic [USAGE_W-1:0] usage_wrk_ff;
   ring_entry_type     rd_data_ff;
   logic               rd_valid_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [USAGE_W-1:0] out_all_ff;
   logic [USAGE_W-1:0] out_wrk_ff;
   logic [LEVEL_W-1:0] out_level_ff;
   logic               out_chg_ff;

   ring_entry_type ring_mem [HISTORY_DEPTH];

   logic [CORES_W-1:0]    cores_eff;
   logic [INTERVAL_W-1:0] interval_eff;
   logic [NUM_W-1:0]      delta_sel;
   logic [NUM_W-1:0]      num_in;
   logic                  div_busy;
   logic [USAGE_W-1:0]    div_q;
   logic                  go_down;
   logic                  go_up;
   logic [LEVEL_W-1:0]    level_in;
   logic                  changed;
   logic [AW-1:0]         head_in;
   logic [CW-1:0]         age_c;
   logic [CW-1:0]         idx_sum;
   logic [AW-1:0]         rd_idx;
   ring_entry_type        wr_entry;

   // Zero divides as one
   assign cores_eff    = (cores_ff == '0) ? CORES_W'(1) : cores_ff;
   assign interval_eff = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;

   // Times 100 as shift and add
   assign delta_sel = NUM_W'(cmd.sel_wrk ? delta_wrk_ff : delta_all_ff);
   assign num_in    = (delta_sel << 6) + (delta_sel << 5) + (delta_sel << 2);

   // Level hysteresis
   assign go_down = (usage_all_ff > upper_ff) || (usage_wrk_ff > upper_ff);
   assign go_up   = (usage_all_ff < lower_ff) || (usage_wrk_ff < lower_ff);

   always_comb begin
      level_in = level_ff;
      changed  = 1'b0;
      if (go_down && (level_ff > LEVEL_MIN)) begin
         level_in = level_ff - 1'b1;
         changed  = 1'b1;
      end else if (go_up && (level_ff < LEVEL_MAX)) begin
         level_in = level_ff + 1'b1;
         changed  = 1'b1;
      end
   end

   assign head_in  = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign wr_entry = '{all_pc: usage_all_ff, wrk_pc: usage_wrk_ff, level: level_in};

   // History address: clamp age to oldest entry, then head - age modulo depth
   always_comb begin
      age_c = CW'(age_ff);
      if (age_c > CW'(HISTORY_DEPTH - 1)) begin
         age_c = CW'(HISTORY_DEPTH - 1);
      end
      idx_sum = CW'(head_ff) + CW'(HISTORY_DEPTH) - age_c;
      if (idx_sum >= CW'(HISTORY_DEPTH)) begin
         idx_sum = idx_sum - CW'(HISTORY_DEPTH);
      end
      rd_idx = idx_sum[AW-1:0];
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cores_ff    <= CORES_RST;
         interval_ff <= INTERVAL_RST;
         upper_ff    <= UPPER_RST;
         lower_ff    <= LOWER_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_CORES:     cores_ff    <= csr_wdata[CORES_W-1:0];
            CSR_TICK_INTERVAL: interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_UPPER_THRESH:  upper_ff    <= csr_wdata[THRESH_W-1:0];
            CSR_LOWER_THRESH:  lower_ff    <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Item capture and working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_type'(req_func);
         pt_ff   <= req_process_time_ms;
         tt_ff   <= req_thread_time_ms;
         age_ff  <= req_history_age;
      end
      if (cmd.load) begin
         delta_all_ff <= pt_ff - last_p_ff;
         delta_wrk_ff <= tt_ff - last_t_ff;
         den_all_ff   <= {{INTERVAL_W{1'b0}}, cores_eff} * {{CORES_W{1'b0}}, interval_eff};
      end
      if (cmd.scale) begin
         num_ff <= num_in;
         den_ff <= cmd.sel_wrk ? DEN_W'(interval_eff) : den_all_ff;
      end
      if (cmd.store_all) begin
         usage_all_ff <= div_q;
      end
      if (cmd.store_wrk) begin
         usage_wrk_ff <= div_q;
      end
   end

   // Tick state: previous counters, level, ring head and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         last_p_ff <= '0;
         last_t_ff <= '0;
         level_ff  <= LEVEL_MAX;
         head_ff   <= '0;
         fill_ff   <= '0;
      end else if (cmd.update) begin
         last_p_ff <= pt_ff;
         last_t_ff <= tt_ff;
         level_ff  <= level_in;
         head_ff   <= head_in;
         if (fill_ff != FW'(HISTORY_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // History ring memory
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[head_in] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         rd_data_ff  <= ring_mem[rd_idx];
         rd_valid_ff <= age_c < CW'(fill_ff);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update || cmd.out_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_all_ff   <= usage_all_ff;
         out_wrk_ff   <= usage_wrk_ff;
         out_level_ff <= level_in;
         out_chg_ff   <= changed;
      end else if (cmd.out_read) begin
         // entries never written read as their reset value
         out_all_ff   <= rd_valid_ff ? rd_data_ff.all_pc : '0;
         out_wrk_ff   <= rd_valid_ff ? rd_data_ff.wrk_pc : '0;
         out_level_ff <= rd_valid_ff ? rd_data_ff.level : LEVEL_MAX;
         out_chg_ff   <= 1'b0;
      end
   end

   clhg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (num_ff),
      .den      (den_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign status.is_read  = (func_ff == FUNC_READ);
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_usage_all_pc    = out_all_ff;
   assign rsp_usage_worker_pc = out_wrk_ff;
   assign rsp_perf_level      = out_level_ff;
   assign rsp_level_changed   = out_chg_ff;

   // Level stays within its range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (level_ff >= LEVEL_MIN) && (level_ff <= LEVEL_MAX))
      else $error("level out of range");

   // Ring head and fill count stay within the depth
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= AW'(HISTORY_DEPTH - 1))
      else $error("ring head out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(HISTORY_DEPTH))
      else $error("fill count out of range");

endmodule

// ===== rtl/core/clhg_ctrl.sv =====
// Controller state machine sequencing ticks and history reads.
module clhg_ctrl import clhg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_read) begin
               state_in = ST_READ_ADDR;
            end else begin
               cmd.load = 1'b1;
               state_in = ST_SCALE_ALL;
            end
         end
         ST_SCALE_ALL: begin
            cmd.scale = 1'b1;
            state_in  = ST_START_ALL;
         end
         ST_START_ALL: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_ALL;
         end
         ST_WAIT_ALL: begin
            if (!status.div_busy) begin
               cmd.store_all = 1'b1;
               state_in      = ST_SCALE_WRK;
            end
         end
         ST_SCALE_WRK: begin
            cmd.scale   = 1'b1;
            cmd.sel_wrk = 1'b1;
            state_in    = ST_START_WRK;
         end
         ST_START_WRK: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_WRK;
         end
         ST_WAIT_WRK: begin
            if (!status.div_busy) begin
               cmd.store_wrk = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_READ_ADDR: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            if (status.out_free) begin
               cmd.out_read = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Divider is started only when idle and is busy right after
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");

   // A new item never finds the divider running
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !status.div_busy)
      else $error("divider busy at item start");

endmodule
